/* design/fau_pkg.sv */
`default_nettype none
package fau_pkg;

    localparam int WORD_BITS = 32;
    localparam int FRAC_POINT = 31;
    localparam logic [WORD_BITS-1:0] FRAC_UNITY = 32'h8000_0000;

    localparam logic [2:0] ACT_CREATE     = 3'd0;
    localparam logic [2:0] ACT_MULTIPLY   = 3'd1;
    localparam logic [2:0] ACT_INV_SCALE  = 3'd2;
    localparam logic [2:0] ACT_ADD        = 3'd3;
    localparam logic [2:0] ACT_COMPLEMENT = 3'd4;
    localparam logic [2:0] ACT_COMPARE    = 3'd5;

    localparam logic signed [1:0] ORD_LESS    = 2'b11;
    localparam logic signed [1:0] ORD_EQUAL   = 2'b00;
    localparam logic signed [1:0] ORD_GREATER = 2'b01;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_LEN   = 7'b0000010,
        S_HALVE = 7'b0000100,
        S_MUL   = 7'b0001000,
        S_DIV   = 7'b0010000,
        S_POST  = 7'b0100000,
        S_FIN   = 7'b1000000
    } state_t;

endpackage
`default_nettype wire

/* design/fraction_arithmetic_unit_top.sv */
// Channel   Handshake               Payload
// input     in_valid / in_ready     action, operand_a, operand_b
// output    out_valid / out_ready   result, order
//
// Add, complement, compare and unused codes go through S_FIN to the output register.
// Create and inverse scale: a leading-zero scan (one bit a cycle) and a restoring
// 32-step divider.
// Multiply: the same scan, up to 32 prescale steps, one 32x32 multiply and a shift.
// in_ready is high only while the sequencer is idle; a finished result waits in
// the output register, so the next item is taken while it stalls.
// Reset (rst_n, asynchronous) returns the sequencer to idle and drops out_valid.
`default_nettype none
module fraction_arithmetic_unit_top
    import fau_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [2:0]         action,
    input  wire logic [31:0]        operand_a,
    input  wire logic [31:0]        operand_b,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [31:0]             result,
    output logic signed [1:0]       order
);

    state_t             state_reg, state_next;
    logic [2:0]         op_reg, op_next;
    logic [31:0]        a_reg, a_next;
    logic [31:0]        b_reg, b_next;
    logic [31:0]        ta_reg, ta_next;
    logic [31:0]        tb_reg, tb_next;
    logic [5:0]         lza_reg, lza_next;
    logic [5:0]         lzb_reg, lzb_next;
    logic [6:0]         used_reg, used_next;
    logic [5:0]         steps_reg, steps_next;
    logic [4:0]         cnt_reg, cnt_next;
    logic [31:0]        rem_reg, rem_next;
    logic [31:0]        quo_reg, quo_next;
    logic [31:0]        div_reg, div_next;
    logic [31:0]        res_reg, res_next;
    logic signed [1:0]  ord_reg, ord_next;
    logic               out_valid_reg, out_valid_next;
    logic [31:0]        result_reg, result_next;
    logic signed [1:0]  order_reg, order_next;

    logic               done_a, done_b;
    logic [32:0]        trial;
    logic [31:0]        inv_div;
    logic [4:0]         back_shift;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign result    = result_reg;
    assign order     = order_reg;

    assign done_a     = ta_reg[31] || (lza_reg == 6'd32);
    assign done_b     = tb_reg[31] || (lzb_reg == 6'd32);
    assign back_shift = 5'd31 - lza_reg[4:0];
    assign inv_div    = b_reg >> back_shift;
    assign trial      = {rem_reg, quo_reg[31]} - {1'b0, div_reg};

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        ta_next        = ta_reg;
        tb_next        = tb_reg;
        lza_next       = lza_reg;
        lzb_next       = lzb_reg;
        used_next      = used_reg;
        steps_next     = steps_reg;
        cnt_next       = cnt_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        div_next       = div_reg;
        res_next       = res_reg;
        ord_next       = ord_reg;
        out_valid_next = out_valid_reg;
        result_next    = result_reg;
        order_next     = order_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next    = action;
                    a_next     = operand_a;
                    b_next     = operand_b;
                    ta_next    = operand_a;
                    tb_next    = operand_b;
                    lza_next   = 6'd0;
                    lzb_next   = 6'd0;
                    steps_next = 6'd0;
                    res_next   = '0;
                    ord_next   = ORD_EQUAL;
                    state_next = S_FIN;
                    unique case (action) inside
                        ACT_CREATE, ACT_MULTIPLY, ACT_INV_SCALE:
                        begin
                            state_next = S_LEN;
                        end
                        ACT_ADD:
                        begin
                            res_next = (operand_a + operand_b < FRAC_UNITY)
                                     ? operand_a + operand_b : FRAC_UNITY;
                        end
                        ACT_COMPLEMENT:
                        begin
                            res_next = FRAC_UNITY - operand_a;
                        end
                        ACT_COMPARE:
                        begin
                            if (operand_a < operand_b)
                                ord_next = ORD_LESS;
                            else if (operand_b < operand_a)
                                ord_next = ORD_GREATER;
                        end
                        default:
                        begin
                            res_next = '0;
                        end
                    endcase
                end
            end
            S_LEN:
            begin
                // count leading zeros of both operands, one bit a cycle
                if (!done_a)
                begin
                    ta_next  = {ta_reg[30:0], 1'b0};
                    lza_next = lza_reg + 6'd1;
                end
                if (!done_b)
                begin
                    tb_next  = {tb_reg[30:0], 1'b0};
                    lzb_next = lzb_reg + 6'd1;
                end
                if (done_a && done_b)
                begin
                    rem_next = '0;
                    cnt_next = 5'd0;
                    quo_next = ta_reg;
                    if (op_reg == ACT_MULTIPLY)
                    begin
                        used_next  = 7'd64 - {1'b0, lza_reg} - {1'b0, lzb_reg};
                        state_next = S_HALVE;
                    end
                    else if (lza_reg == 6'd32)
                    begin
                        res_next   = '0;
                        state_next = S_FIN;
                    end
                    else if (op_reg == ACT_CREATE)
                    begin
                        div_next   = (b_reg < a_reg) ? a_reg : b_reg;
                        state_next = S_DIV;
                    end
                    else
                    begin
                        div_next = inv_div;
                        if (inv_div == '0)
                        begin
                            res_next   = '0;
                            state_next = S_FIN;
                        end
                        else
                        begin
                            state_next = S_DIV;
                        end
                    end
                end
            end
            S_HALVE:
            begin
                if (used_reg > 7'd32)
                begin
                    if (!b_reg[0] || (a_reg[0] && a_reg < b_reg))
                        b_next = b_reg >> 1;
                    else
                        a_next = a_reg >> 1;
                    used_next  = used_reg - 7'd1;
                    steps_next = steps_reg + 6'd1;
                end
                else
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                quo_next   = a_reg * b_reg;
                state_next = S_POST;
            end
            S_DIV:
            begin
                // restoring divide: dividend shifts out of quo, quotient bits shift in
                if (!trial[32])
                begin
                    rem_next = trial[31:0];
                    quo_next = {quo_reg[30:0], 1'b1};
                end
                else
                begin
                    rem_next = {rem_reg[30:0], quo_reg[31]};
                    quo_next = {quo_reg[30:0], 1'b0};
                end
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                    state_next = S_POST;
            end
            S_POST:
            begin
                unique case (op_reg)
                    ACT_MULTIPLY:
                    begin
                        if (steps_reg == 6'd32)
                            res_next = {quo_reg[30:0], 1'b0};
                        else
                            res_next = quo_reg >> (5'd31 - steps_reg[4:0]);
                    end
                    ACT_CREATE:
                    begin
                        res_next = quo_reg << back_shift;
                    end
                    default:
                    begin
                        res_next = quo_reg;
                    end
                endcase
                state_next = S_FIN;
            end
            S_FIN:
            begin
                // hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    result_next    = res_reg;
                    order_next     = ord_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        ta_reg     <= ta_next;
        tb_reg     <= tb_next;
        lza_reg    <= lza_next;
        lzb_reg    <= lzb_next;
        used_reg   <= used_next;
        steps_reg  <= steps_next;
        cnt_reg    <= cnt_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        div_reg    <= div_next;
        res_reg    <= res_next;
        ord_reg    <= ord_next;
        result_reg <= result_next;
        order_reg  <= order_next;
    end

endmodule
`default_nettype wire
